>>> rtl/hap_pkg.sv
package hap_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int GAIN_FRAC_DEF   = 30;

    localparam int GAIN_BITS    = 32;
    localparam int CH_COUNT     = 3;
    localparam int AZ_BITS      = 16;
    localparam int LEN_BITS     = 16;
    localparam int CORDIC_STEPS = 30;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 16'd64;

    // CORDIC gain compensation and sqrt(1/2), both Q30
    localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032874;
    localparam logic signed [31:0] W_TARGET_Q30 = 32'sd759250125;

    // atan(2^-i) on a 2^32 circle
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    localparam logic [1:0] CH_W = 2'd0;
    localparam logic [1:0] CH_X = 2'd1;
    localparam logic [1:0] CH_Y = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_TARGET,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_GAIN,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } t_state;

endpackage

>>> rtl/horizontal_ambisonic_panner_ramp_unit.sv
// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid/tready/tdata/tuser       azimuth, sample, mix_w/x/y; tuser = first_of_chunk
// m_axis    out  tvalid/tready/tdata             out_w, out_x, out_y
// cfg       in   i_cfg_valid/o_cfg_ready/data    chunk_length
//
// One request at a time: s_axis_tready is high only while the sequencer is idle.
// Plain item: per channel, a gain update, a multiply and a round/add/saturate step.
// Chunk start adds 30 CORDIC rotations on one shift/add unit, then three
// 34-step restoring divisions, one quotient bit per cycle.
// Synchronous active-low reset clears gains, steps and the output valid, and
// sets chunk_length to 64. A stalled m_axis holds the result; no new request is
// taken until it has moved into the output register.
module horizontal_ambisonic_panner_ramp_unit #(
    parameter int SAMPLE_BITS    = hap_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = hap_pkg::GAIN_FRAC_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // azimuth, sample, mix_w, mix_x, mix_y (low to high), zero padded
    input  logic [((hap_pkg::AZ_BITS+4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // first_of_chunk
    input  logic                                     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // out_w, out_x, out_y (low to high), zero padded
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [hap_pkg::LEN_BITS-1:0]             i_cfg_data
);
    import hap_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int PW      = GAIN_BITS + SB;
    localparam int ACC_W   = PW + 2;
    localparam int TGT_W   = 34;
    localparam int DIFF_W  = 35;
    localparam int DIV_BITS = DIFF_W - 1;
    localparam int TGT_SH  = 30 - GAIN_FRAC_BITS;

    localparam logic signed [TGT_W-1:0] TGT_RND = TGT_W'((64'sd1 <<< TGT_SH) >>> 1);
    localparam logic signed [TGT_W-1:0] W_TGT   =
        (TGT_W'(W_TARGET_Q30) + TGT_RND) >>> TGT_SH;
    localparam logic signed [ACC_W-1:0] P_RND   = ACC_W'(64'sd1 <<< (GAIN_FRAC_BITS - 1));

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic [LEN_BITS-1:0] r_chunk, n_chunk;
    logic signed [GAIN_BITS-1:0] r_gain [CH_COUNT];
    logic signed [GAIN_BITS-1:0] n_gain [CH_COUNT];
    logic signed [GAIN_BITS-1:0] r_step [CH_COUNT];
    logic signed [GAIN_BITS-1:0] n_step [CH_COUNT];

    logic signed [SB-1:0]    r_smp, n_smp;
    logic signed [SB-1:0]    r_mix [CH_COUNT];
    logic signed [SB-1:0]    n_mix [CH_COUNT];
    logic signed [SB-1:0]    r_res [CH_COUNT];
    logic signed [SB-1:0]    n_res [CH_COUNT];
    logic signed [SB-1:0]    r_out [CH_COUNT];
    logic signed [SB-1:0]    n_out [CH_COUNT];
    logic signed [TGT_W-1:0] r_tgt [CH_COUNT];
    logic signed [TGT_W-1:0] n_tgt [CH_COUNT];
    logic signed [TGT_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [32:0]      r_z, n_z;
    logic                    r_neg, n_neg;
    logic [5:0]              r_iter, n_iter;
    logic [1:0]              r_ch, n_ch;
    logic [DIV_BITS-1:0]     r_dvd, n_dvd;
    logic [LEN_BITS-1:0]     r_rem, n_rem;
    logic                    r_qneg, n_qneg;
    logic signed [PW-1:0]    r_prod, n_prod;

    // combinational temporaries
    logic                    in_take;
    logic [31:0]             u_phase;
    logic signed [TGT_W-1:0] x_sh, y_sh, c_val, s_val;
    logic signed [32:0]      at_val;
    logic signed [DIFF_W-1:0] diff;
    logic [LEN_BITS-1:0]     len_eff;
    logic [LEN_BITS:0]       rem_sh;
    logic                    q_bit;
    logic signed [DIFF_W-1:0] q_val;
    logic signed [GAIN_BITS-1:0] q_sat;
    logic signed [GAIN_BITS:0] g_sum;
    logic signed [ACC_W-1:0] rnd_sum, acc_sum;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign len_eff       = (r_chunk == '0) ? LEN_BITS'(1) : r_chunk;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[0 +: SB]    = r_out[CH_W];
        m_axis_tdata[SB +: SB]   = r_out[CH_X];
        m_axis_tdata[2*SB +: SB] = r_out[CH_Y];
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_chunk     = r_chunk;
        n_gain      = r_gain;
        n_step      = r_step;
        n_smp       = r_smp;
        n_mix       = r_mix;
        n_res       = r_res;
        n_out       = r_out;
        n_tgt       = r_tgt;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_neg       = r_neg;
        n_iter      = r_iter;
        n_ch        = r_ch;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_qneg      = r_qneg;
        n_prod      = r_prod;

        // left half plane: rotate by 180 degrees, negate afterwards
        u_phase = {s_axis_tdata[AZ_BITS-1:0], 16'h0000};
        u_phase[31] = u_phase[31] ^ (s_axis_tdata[15] ^ s_axis_tdata[14]);

        x_sh   = r_x >>> r_iter[4:0];
        y_sh   = r_y >>> r_iter[4:0];
        at_val = $signed({1'b0, ATAN_TAB[r_iter[4:0]]});
        c_val  = r_neg ? -r_x : r_x;
        s_val  = r_neg ? -r_y : r_y;

        diff   = DIFF_W'(r_tgt[r_ch]) - DIFF_W'(r_gain[r_ch]);
        rem_sh = {r_rem, r_dvd[DIV_BITS-1]};
        q_bit  = (rem_sh >= {1'b0, len_eff});
        q_val  = r_qneg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
        if (q_val[DIFF_W-1:GAIN_BITS-1] != {(DIFF_W-GAIN_BITS+1){q_val[DIFF_W-1]}}) begin
            q_sat = q_val[DIFF_W-1] ? {1'b1, {(GAIN_BITS-1){1'b0}}}
                                    : {1'b0, {(GAIN_BITS-1){1'b1}}};
        end else begin
            q_sat = q_val[GAIN_BITS-1:0];
        end

        g_sum = (GAIN_BITS+1)'(r_gain[r_ch]) + (GAIN_BITS+1)'(r_step[r_ch]);

        rnd_sum = ACC_W'(r_prod) + P_RND;
        acc_sum = (rnd_sum >>> GAIN_FRAC_BITS) + ACC_W'(r_mix[r_ch]);

        if (i_cfg_valid) begin
            n_chunk = i_cfg_data;
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_smp       = s_axis_tdata[AZ_BITS +: SB];
                    n_mix[CH_W] = s_axis_tdata[AZ_BITS+SB +: SB];
                    n_mix[CH_X] = s_axis_tdata[AZ_BITS+2*SB +: SB];
                    n_mix[CH_Y] = s_axis_tdata[AZ_BITS+3*SB +: SB];
                    n_x    = TGT_W'(CORDIC_K_Q30);
                    n_y    = '0;
                    n_z    = $signed({u_phase[31], u_phase});
                    n_neg  = s_axis_tdata[15] ^ s_axis_tdata[14];
                    n_iter = '0;
                    n_ch   = CH_W;
                    n_state = s_axis_tuser ? ST_CORDIC : ST_GAIN;
                end
            end
            ST_CORDIC: begin
                if (!r_z[32]) begin
                    n_x = r_x - y_sh;
                    n_y = r_y + x_sh;
                    n_z = r_z - at_val;
                end else begin
                    n_x = r_x + y_sh;
                    n_y = r_y - x_sh;
                    n_z = r_z + at_val;
                end
                n_iter = r_iter + 6'd1;
                if (r_iter == 6'(CORDIC_STEPS - 1)) begin
                    n_state = ST_TARGET;
                end
            end
            ST_TARGET: begin
                n_tgt[CH_W] = W_TGT;
                n_tgt[CH_X] = (c_val + TGT_RND) >>> TGT_SH;
                n_tgt[CH_Y] = (s_val + TGT_RND) >>> TGT_SH;
                n_ch    = CH_W;
                n_state = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                n_qneg  = diff[DIFF_W-1];
                n_dvd   = diff[DIFF_W-1] ? DIV_BITS'(-diff) : DIV_BITS'(diff);
                n_rem   = '0;
                n_iter  = '0;
                n_state = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                // restoring divide, quotient shifts in where the dividend leaves
                n_rem  = q_bit ? LEN_BITS'(rem_sh - {1'b0, len_eff}) : rem_sh[LEN_BITS-1:0];
                n_dvd  = {r_dvd[DIV_BITS-2:0], q_bit};
                n_iter = r_iter + 6'd1;
                if (r_iter == 6'(DIV_BITS - 1)) begin
                    n_state = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                n_step[r_ch] = q_sat;
                if (r_ch == CH_Y) begin
                    n_ch    = CH_W;
                    n_state = ST_GAIN;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = ST_DIV_LOAD;
                end
            end
            ST_GAIN: begin
                if (g_sum[GAIN_BITS] != g_sum[GAIN_BITS-1]) begin
                    n_gain[r_ch] = g_sum[GAIN_BITS] ? {1'b1, {(GAIN_BITS-1){1'b0}}}
                                                    : {1'b0, {(GAIN_BITS-1){1'b1}}};
                end else begin
                    n_gain[r_ch] = g_sum[GAIN_BITS-1:0];
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod  = r_gain[r_ch] * r_smp;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (acc_sum[ACC_W-1:SB-1] != {(ACC_W-SB+1){acc_sum[ACC_W-1]}}) begin
                    n_res[r_ch] = acc_sum[ACC_W-1] ? {1'b1, {(SB-1){1'b0}}}
                                                   : {1'b0, {(SB-1){1'b1}}};
                end else begin
                    n_res[r_ch] = acc_sum[SB-1:0];
                end
                if (r_ch == CH_Y) begin
                    n_state = ST_OUT;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = ST_GAIN;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_chunk     <= LEN_RESET;
            r_gain      <= '{default: '0};
            r_step      <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chunk     <= n_chunk;
            r_gain      <= n_gain;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp  <= n_smp;
        r_mix  <= n_mix;
        r_res  <= n_res;
        r_out  <= n_out;
        r_tgt  <= n_tgt;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_neg  <= n_neg;
        r_iter <= n_iter;
        r_ch   <= n_ch;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_qneg <= n_qneg;
        r_prod <= n_prod;
    end

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while a previous one is in progress");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && !m_axis_tready) |=>
            (r_state == ST_OUT && $stable(m_axis_tdata)))
        else $error("result overwrote a pending output");

    a_out_only_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_OUT))
        else $error("output valid raised outside of result hand-off");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_CORDIC) |-> (r_ch != 2'd3))
        else $error("channel index out of range");
`endif

endmodule

>>> sim/hap_ramp_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and chunk-length channels of the panner, keeps
// its own copy of the ramp state and checks every result against it.
module hap_ramp_checker #(
    parameter int SAMPLE_BITS    = hap_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = hap_pkg::GAIN_FRAC_DEF,
    parameter int IN_W           = ((hap_pkg::AZ_BITS + 4 * SAMPLE_BITS + 7) / 8) * 8,
    parameter int OUT_W          = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_valid,
    input  logic                         i_s_ready,
    // azimuth, sample, mix_w, mix_x, mix_y (low to high)
    input  logic [IN_W-1:0]              i_s_data,
    // first_of_chunk
    input  logic                         i_s_user,
    input  logic                         i_m_valid,
    input  logic                         i_m_ready,
    // out_w, out_x, out_y (low to high)
    input  logic [OUT_W-1:0]             i_m_data,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [hap_pkg::LEN_BITS-1:0] i_cfg_data,
    output int                           o_errors,
    output int                           o_pending
);
    import hap_pkg::*;

    localparam int SB = SAMPLE_BITS;

    typedef logic [CH_COUNT-1:0][SB-1:0] t_mix_trio;

    const string CH_NAME [CH_COUNT] = '{"out_w", "out_x", "out_y"};

    logic [LEN_BITS-1:0] chunk_len;
    longint              gain_now  [CH_COUNT];
    longint              gain_step [CH_COUNT];
    t_mix_trio           mix_due [$];
    int                  mismatches;

    function automatic longint round_shr(input longint v, input int n);
        if (n == 0) return v;
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input int bits);
        longint hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advances the gain ramp by one sample and returns the three mixed outputs.
    function automatic t_mix_trio encode_sample(input logic first, input logic [IN_W-1:0] req);
        longint      tgt [CH_COUNT];
        longint      x, y, z, xn, smp, mix, acc, len;
        logic [31:0] ang;
        logic        flip;
        t_mix_trio   res;
        smp = longint'($signed(req[AZ_BITS +: SB]));
        if (first) begin
            ang  = {req[AZ_BITS-1:0], 16'h0000};
            // quadrants 1 and 2: rotate by half a turn, negate afterwards
            flip = ^req[AZ_BITS-1 -: 2];
            if (flip) ang = ang + 32'h8000_0000;
            x = CORDIC_K_Q30;
            y = 0;
            z = longint'($signed(ang));
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    xn = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(ATAN_TAB[i]);
                end else begin
                    xn = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(ATAN_TAB[i]);
                end
                x = xn;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            tgt[CH_W] = round_shr(W_TARGET_Q30, 30 - GAIN_FRAC_BITS);
            tgt[CH_X] = round_shr(x, 30 - GAIN_FRAC_BITS);
            tgt[CH_Y] = round_shr(y, 30 - GAIN_FRAC_BITS);
            len = (chunk_len == 0) ? 64'sd1 : longint'(chunk_len);
            for (int k = 0; k < CH_COUNT; k++)
                gain_step[k] = clamp((tgt[k] - gain_now[k]) / len, GAIN_BITS);
        end
        for (int k = 0; k < CH_COUNT; k++) begin
            mix          = longint'($signed(req[AZ_BITS + (k + 1) * SB +: SB]));
            gain_now[k]  = clamp(gain_now[k] + gain_step[k], GAIN_BITS);
            acc          = round_shr(gain_now[k] * smp, GAIN_FRAC_BITS) + mix;
            res[k]       = SB'(clamp(acc, SB));
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_mix_trio want, got;
        if (!i_rst_n) begin
            chunk_len = LEN_RESET;
            for (int k = 0; k < CH_COUNT; k++) begin
                gain_now[k]  = 0;
                gain_step[k] = 0;
            end
            mix_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) chunk_len = i_cfg_data;
            // retire first: a result never belongs to a request taken on the same edge
            if (i_m_valid && i_m_ready) begin
                got = i_m_data[3*SB-1:0];
                if (mix_due.size() == 0) begin
                    $error("result with no request outstanding: w=%0d x=%0d y=%0d",
                           $signed(got[CH_W]), $signed(got[CH_X]), $signed(got[CH_Y]));
                    mismatches++;
                end else begin
                    want = mix_due.pop_front();
                    for (int k = 0; k < CH_COUNT; k++) begin
                        if (got[k] !== want[k]) begin
                            $error("%s: expected %0d, got %0d", CH_NAME[k],
                                   $signed(want[k]), $signed(got[k]));
                            mismatches++;
                        end
                    end
                end
            end
            if (i_s_valid && i_s_ready)
                mix_due.push_back(encode_sample(i_s_user, i_s_data));
        end
        o_pending <= mix_due.size();
        o_errors  <= mismatches;
    end

endmodule

>>> sim/tb_horizontal_ambisonic_panner_ramp_unit.sv
`timescale 1ns / 1ps

module tb_horizontal_ambisonic_panner_ramp_unit;
    import hap_pkg::*;

    localparam int SB    = SAMPLE_BITS_DEF;
    localparam int IN_W  = ((AZ_BITS + 4 * SB + 7) / 8) * 8;
    localparam int OUT_W = ((3 * SB + 7) / 8) * 8;

    localparam logic [SB-1:0] S_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic [SB-1:0] S_MIN = {1'b1, {(SB - 1){1'b0}}};
    localparam logic [SB-1:0] S_ZERO = '0;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [LEN_BITS-1:0] i_cfg_data    = '0;

    int mix_errors;
    int mix_pending;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_token   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    horizontal_ambisonic_panner_ramp_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    hap_ramp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .i_s_ready   (s_axis_tready),
        .i_s_data    (s_axis_tdata),
        .i_s_user    (s_axis_tuser),
        .i_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .i_m_data    (m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (mix_errors),
        .o_pending   (mix_pending)
    );

    always #5 i_clk = ~i_clk;

    // result side: random stalls, plus a long hold-off whenever the token moves
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen     <= hold_token;
            hold_left     <= 600;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic logic [SB-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SB'($urandom_range(0, 3)) - SB'(1);
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [AZ_BITS-1:0] pick_azimuth();
        if ($urandom_range(0, 9) == 0)
            return AZ_BITS'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
        return AZ_BITS'($urandom);
    endfunction

    task automatic offer_request(input logic first, input logic [AZ_BITS-1:0] az,
                                 input logic [SB-1:0] smp, mw, mx, my);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= first;
        s_axis_tdata  <= IN_W'({my, mx, mw, smp, az});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (mix_pending != 0);
    endtask

    task automatic write_chunk_length(input logic [LEN_BITS-1:0] len);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly chunks (cut to at most 40 requests) with random content, some noise and some overruns
    task automatic run_phase(input int len, input int n_items);
        int sent, chunk;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                offer_request(1'($urandom), pick_azimuth(), pick_level(), pick_level(),
                              pick_level(), pick_level());
                sent++;
            end else begin
                chunk = (len == 0) ? 1 : len;
                if (chunk > 40) chunk = $urandom_range(1, 40);
                // run past the chunk end now and then: gains keep ramping
                if ($urandom_range(0, 9) == 0) chunk += $urandom_range(1, 3);
                for (int j = 0; j < chunk && sent < n_items; j++) begin
                    offer_request(j == 0, pick_azimuth(), pick_level(), pick_level(),
                                  pick_level(), pick_level());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int phase_len [8];
        int tx_mode [4];
        int rx_mode [4];
        phase_len = '{1, 0, 65535, 8, 16, 3, 40000, 5};
        tx_mode   = '{0, 47, 0, 14};
        rx_mode   = '{0, 0, 47, 14};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset chunk length, zero gains, quadrant edges, full-scale sums
        offer_request(1'b0, 16'd0,     S_MAX, S_ZERO, S_MAX, S_MIN);
        offer_request(1'b1, 16'd0,     S_MAX, S_MAX, S_MAX, S_MAX);
        offer_request(1'b1, 16'd16384, S_MIN, S_MIN, S_MIN, S_MIN);
        offer_request(1'b1, 16'd32768, S_MAX, S_ZERO, S_ZERO, S_ZERO);
        offer_request(1'b1, 16'd49152, S_MIN, S_MAX, S_MIN, S_ZERO);
        offer_request(1'b1, 16'd65535, S_MAX, S_MIN, S_MAX, S_MAX);
        offer_request(1'b1, 16'd16383, S_MAX, S_ZERO, S_ZERO, S_ZERO);
        offer_request(1'b1, 16'd32767, S_MIN, S_ZERO, S_ZERO, S_ZERO);
        offer_request(1'b0, 16'd12345, S_MAX, S_MAX, S_MIN, S_MAX);

        // one-sample chunks: swing X from -1 to +1, then overrun into saturation
        write_chunk_length(16'd1);
        offer_request(1'b1, 16'd32768, S_MAX, S_ZERO, S_ZERO, S_ZERO);
        offer_request(1'b1, 16'd0,     S_MIN, S_ZERO, S_ZERO, S_ZERO);
        offer_request(1'b0, 16'd0,     S_MIN, S_MIN, S_MIN, S_MIN);
        offer_request(1'b0, 16'd0,     S_MAX, S_MAX, S_MAX, S_MAX);
        offer_request(1'b0, 16'd0,     S_MIN, S_MAX, S_MAX, S_MAX);

        // zero length behaves as one
        write_chunk_length(16'd0);
        offer_request(1'b1, 16'd8192,  S_MAX, S_ZERO, S_ZERO, S_ZERO);
        offer_request(1'b0, 16'd8192,  S_MIN, S_ZERO, S_ZERO, S_ZERO);
        offer_request(1'b1, 16'd40960, S_MAX, S_MIN, S_MAX, S_ZERO);

        for (int p = 0; p < 8; p++) begin
            tx_idle_pct  = tx_mode[p % 4];
            rx_stall_pct = rx_mode[p % 4];
            write_chunk_length(LEN_BITS'(phase_len[p]));
            // back up the result side while requests keep coming
            if (p == 1 || p == 5) hold_token++;
            run_phase(phase_len[p], 155);
        end

        drain_results();
        repeat (200) @(posedge i_clk);
        if (mix_errors == 0) begin
            $display("horizontal_ambisonic_panner_ramp_unit verification clean");
        end else begin
            $display("horizontal_ambisonic_panner_ramp_unit verification failed");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("horizontal_ambisonic_panner_ramp_unit verification failed");
        $finish;
    end

endmodule
